@@ hw/rtl/pid4_pkg.sv @@
// ----------------------------------------------------------------------------
// pid4_pkg
// Shared widths, constants and types of the packed int4 dot product block.
// ----------------------------------------------------------------------------
package pid4_pkg;

  localparam int BYTE_W     = 8;
  localparam int NIB_W      = 4;
  localparam int WORD_BYTES = 8;
  localparam int WORD_W     = WORD_BYTES * BYTE_W;
  localparam int LANE_BYTES = 8;
  localparam int NUM_LANES  = (LANE_BYTES < WORD_BYTES) ? LANE_BYTES : WORD_BYTES;
  localparam int VB_W       = 4;

  // one nibble product fits 8 bits signed, two of them 9 bits
  localparam int PROD_W = 2 * NIB_W + 1;
  localparam int SUM_W  = PROD_W + $clog2(NUM_LANES);
  localparam int ACC_W  = 21;
  localparam int F32_W  = 32;

  localparam int IN_FIELDS_W  = 2 * WORD_W + VB_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + BYTE_W - 1) / BYTE_W) * BYTE_W;
  localparam int OUT_FIELDS_W = ACC_W + F32_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + BYTE_W - 1) / BYTE_W) * BYTE_W;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef logic [NUM_LANES-1:0][PROD_W-1:0] lane_vec_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic                    last;
  } item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] sum;
    logic                    clip;
  } acc_res_t;

  typedef struct packed {
    logic                    saturated;
    logic [F32_W-1:0]        result_float;
    logic signed [ACC_W-1:0] dot_sum;
  } result_t;

endpackage

@@ hw/rtl/pid4_lane.sv @@
// ----------------------------------------------------------------------------
// pid4_lane
// One byte lane: low*low plus high*high of two packed signed nibble pairs.
// ----------------------------------------------------------------------------
module pid4_lane import pid4_pkg::*; (
  input  logic [BYTE_W-1:0]        lhs_i,
  input  logic [BYTE_W-1:0]        rhs_i,
  input  logic                     en_i,
  output logic signed [PROD_W-1:0] sum_o
);

  logic signed [2*NIB_W-1:0] prod_lo;
  logic signed [2*NIB_W-1:0] prod_hi;

  assign prod_lo = signed'(lhs_i[NIB_W-1:0]) * signed'(rhs_i[NIB_W-1:0]);
  assign prod_hi = signed'(lhs_i[BYTE_W-1:NIB_W]) * signed'(rhs_i[BYTE_W-1:NIB_W]);

  assign sum_o = en_i ? (PROD_W'(prod_lo) + PROD_W'(prod_hi)) : '0;

endmodule

@@ hw/rtl/pid4_merge.sv @@
// ----------------------------------------------------------------------------
// pid4_merge
// Registers the lane results and adds them into one item sum (two stages).
// ----------------------------------------------------------------------------
module pid4_merge import pid4_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  lane_vec_t lane_sum_i,
  input  logic      in_last_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output item_t     out_o
);

  logic      lane_v_q;
  lane_vec_t lanes_q;
  logic      lane_last_q;
  logic      sum_v_q;
  item_t     item_q;
  logic      lane_rdy;
  logic      sum_rdy;
  logic signed [SUM_W-1:0] sum_d;

  assign sum_rdy  = !sum_v_q || out_ready_i;
  assign lane_rdy = !lane_v_q || sum_rdy;

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      sum_d = sum_d + SUM_W'(signed'(lanes_q[i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_v_q <= 1'b0;
      sum_v_q  <= 1'b0;
    end else begin
      if (lane_rdy) lane_v_q <= in_valid_i;
      if (sum_rdy)  sum_v_q  <= lane_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lane_rdy && in_valid_i) begin
      lanes_q     <= lane_sum_i;
      lane_last_q <= in_last_i;
    end
    if (sum_rdy && lane_v_q) begin
      item_q.sum  <= sum_d;
      item_q.last <= lane_last_q;
    end
  end

  assign in_ready_o  = lane_rdy;
  assign out_valid_o = sum_v_q;
  assign out_o       = item_q;

endmodule

@@ hw/rtl/pid4_accum.sv @@
// ----------------------------------------------------------------------------
// pid4_accum
// Saturating running sum; emits sum and clip flag on the last item.
// ----------------------------------------------------------------------------
module pid4_accum import pid4_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  item_t    in_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output acc_res_t out_o
);

  logic signed [ACC_W-1:0] run_q, run_d;
  logic                    clip_q, clip_d;
  logic                    res_v_q;
  acc_res_t                res_q;
  logic signed [ACC_W:0]   ext_sum;
  logic                    take;

  assign in_ready_o = !in_i.last || !res_v_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    ext_sum = (ACC_W+1)'(run_q) + (ACC_W+1)'(in_i.sum);
    if (ext_sum[ACC_W] != ext_sum[ACC_W-1]) begin
      run_d  = ext_sum[ACC_W] ? ACC_MIN : ACC_MAX;
      clip_d = 1'b1;
    end else begin
      run_d  = ext_sum[ACC_W-1:0];
      clip_d = clip_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= '0;
      clip_q  <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      if (out_ready_i) res_v_q <= 1'b0;
      if (take) begin
        if (in_i.last) begin
          run_q   <= '0;
          clip_q  <= 1'b0;
          res_v_q <= 1'b1;
        end else begin
          run_q  <= run_d;
          clip_q <= clip_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && in_i.last) begin
      res_q.sum  <= run_d;
      res_q.clip <= clip_d;
    end
  end

  assign out_valid_o = res_v_q;
  assign out_o       = res_q;

endmodule

@@ hw/rtl/pid4_fmt.sv @@
// ----------------------------------------------------------------------------
// pid4_fmt
// Optional saturating negation, then exact int to float32 conversion.
// ----------------------------------------------------------------------------
module pid4_fmt import pid4_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     negate_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  acc_res_t in_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output result_t  out_o
);

  localparam int POS_W  = $clog2(ACC_W);
  localparam int MAN_W  = 23;
  localparam int EXP_W  = 8;
  localparam int F32_BIAS = 127;

  logic                    neg_v_q;
  logic signed [ACC_W-1:0] val_q;
  logic                    sat_q;
  logic                    nz_q;
  logic                    res_v_q;
  result_t                 res_q;
  logic                    neg_rdy;
  logic                    res_rdy;

  logic signed [ACC_W:0]   neg_ext;
  logic signed [ACC_W-1:0] val_d;
  logic                    sat_d;

  logic [ACC_W-1:0]        mag;
  logic [POS_W-1:0]        pos;
  logic [F32_W-1:0]        shifted;
  logic [EXP_W-1:0]        exp_bits;
  logic [F32_W-1:0]        float_d;

  assign res_rdy = !res_v_q || out_ready_i;
  assign neg_rdy = !neg_v_q || res_rdy;

  always_comb begin
    neg_ext = -((ACC_W+1)'(in_i.sum));
    val_d   = in_i.sum;
    sat_d   = in_i.clip;
    if (negate_i) begin
      if (neg_ext[ACC_W] != neg_ext[ACC_W-1]) begin
        val_d = ACC_MAX;
        sat_d = 1'b1;
      end else begin
        val_d = neg_ext[ACC_W-1:0];
      end
    end
  end

  always_comb begin
    mag = val_q[ACC_W-1] ? (~val_q + 1'b1) : val_q;
    pos = '0;
    for (int i = 0; i < ACC_W; i++) begin
      if (mag[i]) pos = POS_W'(i);
    end
    shifted  = F32_W'(mag) << (POS_W'(MAN_W) - pos);
    exp_bits = EXP_W'(F32_BIAS) + EXP_W'(pos);
    if (val_q == '0) begin
      float_d = {nz_q, {(F32_W-1){1'b0}}};
    end else begin
      float_d = {val_q[ACC_W-1], exp_bits, shifted[MAN_W-1:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_v_q <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      if (neg_rdy) neg_v_q <= in_valid_i;
      if (res_rdy) res_v_q <= neg_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (neg_rdy && in_valid_i) begin
      val_q <= val_d;
      sat_q <= sat_d;
      nz_q  <= negate_i;
    end
    if (res_rdy && neg_v_q) begin
      res_q.dot_sum      <= val_q;
      res_q.result_float <= float_d;
      res_q.saturated    <= sat_q;
    end
  end

  assign in_ready_o  = neg_rdy;
  assign out_valid_o = res_v_q;
  assign out_o       = res_q;

endmodule

@@ hw/rtl/packed_int4_dot_product.sv @@
// ----------------------------------------------------------------------------
// packed_int4_dot_product
// Streaming dot product of packed signed 4-bit vectors, int and float32 out.
// ----------------------------------------------------------------------------
// channel  dir  handshake                    payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tdata: lhs, rhs, valid bytes; tlast
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata: dot_sum, float, saturated
// cfg      in   cfg_we_i                     cfg_wdata_i: negate_result
//
// One input transfer per cycle while s_axis_tready is high; the accumulator add and clip is the loop.
// m_axis_tvalid rises once the tlast transfer has passed the lane, item sum,
// accumulator result, negate and float result registers in that order.
// Reset clears all stage valids, the running sum, clip flag and mode bit.
// Backpressure moves stage by stage; non-last transfers keep flowing while
// a result waits on m_axis.
// ----------------------------------------------------------------------------
module packed_int4_dot_product import pid4_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [63:0] lhs_word, [127:64] rhs_word, [131:128] valid_bytes, rest zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [20:0] dot_sum, [52:21] result_float, [53] saturated, rest zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i
);

  logic      negate_q;
  lane_vec_t lane_sum;
  logic [VB_W-1:0] valid_bytes;
  logic      item_v, item_rdy;
  item_t     item;
  logic      acc_v, acc_rdy;
  acc_res_t  acc_res;
  result_t   res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      negate_q <= 1'b0;
    end else if (cfg_we_i) begin
      negate_q <= cfg_wdata_i;
    end
  end

  assign valid_bytes = s_axis_tdata[2*WORD_W +: VB_W];

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    pid4_lane u_lane (
      .lhs_i (s_axis_tdata[g*BYTE_W +: BYTE_W]),
      .rhs_i (s_axis_tdata[WORD_W + g*BYTE_W +: BYTE_W]),
      .en_i  (valid_bytes > VB_W'(g)),
      .sum_o (lane_sum[g])
    );
  end

  pid4_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .lane_sum_i  (lane_sum),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (item_v),
    .out_ready_i (item_rdy),
    .out_o       (item)
  );

  pid4_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_v),
    .in_ready_o  (item_rdy),
    .in_i        (item),
    .out_valid_o (acc_v),
    .out_ready_i (acc_rdy),
    .out_o       (acc_res)
  );

  pid4_fmt u_fmt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .negate_i    (negate_q),
    .in_valid_i  (acc_v),
    .in_ready_o  (acc_rdy),
    .in_i        (acc_res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {(OUT_TDATA_W-OUT_FIELDS_W)'(0), res};

endmodule

@@ hw/rtl/pid4_checker.sv @@
// ----------------------------------------------------------------------------
// pid4_checker
// Port-level checks of the packed int4 dot product, bound to the top level.
// ----------------------------------------------------------------------------
module pid4_checker import pid4_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int F_LO   = ACC_W;
  localparam int F_SIGN = ACC_W + F32_W - 1;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_zero_float: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[ACC_W-1:0] == '0) |->
      (m_axis_tdata[F_SIGN-1:F_LO] == '0))
    else $error("zero sum with nonzero float magnitude");

  a_float_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[ACC_W-1:0] != '0) |->
      (m_axis_tdata[F_SIGN] == m_axis_tdata[ACC_W-1]))
    else $error("float sign differs from integer sign");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind packed_int4_dot_product pid4_checker u_pid4_checker (.*);
